// File: rtl/dqc_pkg.sv
`timescale 1ns / 1ps

package dqc_pkg;

   localparam int DEPTH = 16;
   localparam int DATA_W = 32;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   typedef logic [PTR_W-1:0] ptr_type;
   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [DATA_W-1:0] data_type;

   typedef enum logic [3:0] {
      OP_EMPTY_Q    = 4'd0,
      OP_SIZE_Q     = 4'd1,
      OP_PUSH_FRONT = 4'd2,
      OP_PUSH_BACK  = 4'd3,
      OP_POP_FRONT  = 4'd4,
      OP_POP_BACK   = 4'd5,
      OP_LIST       = 4'd6,
      OP_WALK_START = 4'd7,
      OP_WALK_MOVE  = 4'd8,
      OP_WALK_END   = 4'd9
   } op_type;

   typedef enum logic [1:0] {
      DIR_LEFT  = 2'd0,
      DIR_RIGHT = 2'd1,
      DIR_STAY  = 2'd2
   } dir_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LIST_READ,
      ST_LIST_RESP,
      ST_WALK_READ,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic   exec;
      op_type op;
      logic   next_read;
      logic   load_read;
      logic   read_last;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic list_last;
   } stat_type;

   function automatic ptr_type ring_add(ptr_type base, cnt_type k);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(k);
      if (sum >= SUM_W'(DEPTH)) begin
         sum = sum - SUM_W'(DEPTH);
      end
      return sum[PTR_W-1:0];
   endfunction

   function automatic ptr_type ring_inc(ptr_type p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic ptr_type ring_dec(ptr_type p);
      return (p == '0) ? PTR_W'(DEPTH - 1) : p - 1'b1;
   endfunction

endpackage

// File: rtl/dqc_ctrl.sv
`timescale 1ns / 1ps

module dqc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  dqc_pkg::op_type   req_op,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output dqc_pkg::cmd_type  cmd,
   input  dqc_pkg::stat_type stat
);
   import dqc_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      cmd        = '0;
      cmd.op     = req_op;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.exec = 1'b1;
               unique case (req_op)
                  OP_EMPTY_Q, OP_SIZE_Q, OP_PUSH_FRONT, OP_PUSH_BACK,
                  OP_POP_FRONT, OP_POP_BACK, OP_WALK_START, OP_WALK_MOVE: begin
                     state_in = ST_RESP;
                  end
                  OP_LIST: begin
                     state_in = stat.count_zero ? ST_IDLE : ST_LIST_READ;
                  end
                  OP_WALK_END: begin
                     state_in = stat.count_zero ? ST_RESP : ST_WALK_READ;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_LIST_READ: begin
            cmd.load_read = 1'b1;
            cmd.read_last = stat.list_last;
            state_in      = ST_LIST_RESP;
         end
         ST_WALK_READ: begin
            cmd.load_read = 1'b1;
            cmd.read_last = 1'b1;
            state_in      = ST_RESP;
         end
         ST_LIST_RESP: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (stat.list_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.next_read = 1'b1;
                  state_in      = ST_LIST_READ;
               end
            end
         end
         ST_RESP: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request taken while a result is pending");

   a_list_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LIST_READ) |-> !stat.count_zero)
      else $error("list read with no items held");

   a_read_follows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK_READ) |-> $past(cmd.exec && (req_op == OP_WALK_END)))
      else $error("walk read without a walk end request");

endmodule

// File: rtl/dqc_dpath.sv
`timescale 1ns / 1ps

module dqc_dpath (
   input  logic               clock,
   input  logic               reset,
   input  dqc_pkg::cmd_type   cmd,
   output dqc_pkg::stat_type  stat,
   input  dqc_pkg::data_type  item_value,
   input  logic [1:0]         move_dir,
   output dqc_pkg::data_type  answer,
   output dqc_pkg::status_type status,
   output logic               empty_flag,
   output logic               last
);
   import dqc_pkg::*;

   data_type   store_ff [DEPTH];
   data_type   rdata_ff;
   ptr_type    front_ff, front_in;
   cnt_type    count_ff, count_in;
   cnt_type    cursor_ff, cursor_in;
   cnt_type    idx_ff, idx_in;
   data_type   answer_ff, answer_in;
   status_type status_ff, status_in;
   logic       empty_ff, empty_in;
   logic       last_ff, last_in;
   logic       load_rsp;
   logic       wr_en;
   ptr_type    wr_addr;
   logic       rd_en;
   cnt_type    rd_k;
   ptr_type    rd_addr;
   logic       full;
   logic       zero;
   cnt_type    pos;

   assign full = (count_ff == CNT_W'(DEPTH));
   assign zero = (count_ff == '0);
   assign stat.count_zero = zero;
   assign stat.list_last  = ((idx_ff + 1'b1) == count_ff);

   always_comb begin
      front_in  = front_ff;
      count_in  = count_ff;
      cursor_in = cursor_ff;
      idx_in    = idx_ff;
      wr_en     = 1'b0;
      wr_addr   = ring_add(front_ff, count_ff);
      rd_en     = 1'b0;
      rd_k      = '0;
      load_rsp  = 1'b0;
      answer_in = answer_ff;
      status_in = status_ff;
      empty_in  = empty_ff;
      last_in   = last_ff;
      pos       = (cursor_ff > count_ff) ? count_ff : cursor_ff;
      if (pos == '0) begin
         pos = CNT_W'(1);
      end
      if (cmd.exec) begin
         unique case (cmd.op)
            OP_PUSH_FRONT: begin
               if (!full) begin
                  front_in = ring_dec(front_ff);
                  wr_en    = 1'b1;
                  wr_addr  = ring_dec(front_ff);
                  count_in = count_ff + 1'b1;
               end
            end
            OP_PUSH_BACK: begin
               if (!full) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
            OP_POP_FRONT: begin
               if (!zero) begin
                  front_in = ring_inc(front_ff);
                  count_in = count_ff - 1'b1;
               end
            end
            OP_POP_BACK: begin
               if (!zero) begin
                  count_in = count_ff - 1'b1;
               end
            end
            OP_WALK_START: begin
               cursor_in = CNT_W'(1);
            end
            OP_WALK_MOVE: begin
               if ((move_dir == DIR_LEFT) && (cursor_ff > CNT_W'(1))) begin
                  cursor_in = cursor_ff - 1'b1;
               end else if ((move_dir == DIR_RIGHT) && (cursor_ff < count_ff)) begin
                  cursor_in = cursor_ff + 1'b1;
               end
            end
            OP_LIST: begin
               idx_in = '0;
               rd_en  = !zero;
               rd_k   = '0;
            end
            OP_WALK_END: begin
               rd_en = !zero;
               rd_k  = pos - 1'b1;
            end
            default: begin
            end
         endcase
         if ((cmd.op == OP_WALK_END) && zero) begin
            load_rsp  = 1'b1;
            answer_in = '0;
            status_in = STAT_EMPTY;
            empty_in  = 1'b1;
            last_in   = 1'b1;
         end else if ((cmd.op != OP_LIST) && (cmd.op != OP_WALK_END)
                      && (cmd.op <= OP_WALK_END)) begin
            load_rsp  = 1'b1;
            answer_in = DATA_W'(count_in);
            status_in = (full && ((cmd.op == OP_PUSH_FRONT) || (cmd.op == OP_PUSH_BACK)))
                        ? STAT_FULL : STAT_OK;
            empty_in  = (count_in == '0);
            last_in   = 1'b1;
         end
      end
      if (cmd.next_read) begin
         idx_in = idx_ff + 1'b1;
         rd_en  = 1'b1;
         rd_k   = idx_ff + 1'b1;
      end
      if (cmd.load_read) begin
         load_rsp  = 1'b1;
         answer_in = rdata_ff;
         status_in = STAT_OK;
         empty_in  = zero;
         last_in   = cmd.read_last;
      end
      rd_addr = ring_add(front_ff, rd_k);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff  <= '0;
         count_ff  <= '0;
         cursor_ff <= CNT_W'(1);
         idx_ff    <= '0;
      end else begin
         front_ff  <= front_in;
         count_ff  <= count_in;
         cursor_ff <= cursor_in;
         idx_ff    <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= item_value;
      end
      if (rd_en) begin
         rdata_ff <= store_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         answer_ff <= answer_in;
         status_ff <= status_in;
         empty_ff  <= empty_in;
         last_ff   <= last_in;
      end
   end

   assign answer     = answer_ff;
   assign status     = status_ff;
   assign empty_flag = empty_ff;
   assign last       = last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("item count above store depth");

   a_cursor_nonzero: assert property (@(posedge clock) disable iff (reset)
      cursor_ff != '0)
      else $error("cursor reached zero");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && (cmd.op == OP_PUSH_BACK) && !full)
      |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("push back did not grow the count");

endmodule

// File: rtl/deque_with_cursor.sv
`timescale 1ns / 1ps
// Channel  Direction  Contents
// req_     in         tdata: item_value, move_dir; tuser: req_type
// rsp_     out        tdata: answer; tuser: status, empty_flag; tlast: last
//
// Queries, pushes, pops and walk steps: the result word is valid in the cycle
// after the request is taken. A list or walk end with items held reads the store
// through a registered port: each read word, after the request or after the previous
// word leaves, passes through the read data register and then the answer register.
// Reset clears the count and front pointer and sets the cursor to one.
// While rsp_tready is low the result holds and no new request is taken.

module deque_with_cursor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // [31:0] item_value, [33:32] move_dir, rest zero
   input  logic [3:0]  req_tuser,  // [3:0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // [31:0] answer
   output logic [2:0]  rsp_tuser,  // [1:0] status, [2] empty_flag
   output logic        rsp_tlast
);
   import dqc_pkg::*;

   cmd_type    cmd;
   stat_type   stat;
   data_type   answer;
   status_type status;
   logic       empty_flag;

   dqc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (op_type'(req_tuser)),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   dqc_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .item_value (req_tdata[31:0]),
      .move_dir   (req_tdata[33:32]),
      .answer     (answer),
      .status     (status),
      .empty_flag (empty_flag),
      .last       (rsp_tlast)
   );

   assign rsp_tdata = answer;
   assign rsp_tuser = {empty_flag, status};

endmodule

// File: tb/deque_with_cursor_test.sv
`timescale 1ns / 1ps

module deque_with_cursor_test;
   import dqc_pkg::*;

   localparam int LIMIT = 400000;
   localparam int LONG_STALL = 400;
   localparam int CHUNKS = 8;
   localparam int CHUNK_ITEMS = 50;

   typedef struct packed {
      logic [3:0] op;
      data_type   value;
      logic [1:0] dir;
   } request_t;

   typedef struct packed {
      data_type   answer;
      status_type status;
      logic       empty;
      logic       last;
   } answer_word_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;  // [31:0] item_value, [33:32] move_dir, rest zero
   logic [3:0]  req_tuser = '0;  // [3:0] req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;       // [31:0] answer
   logic [2:0]  rsp_tuser;       // [1:0] status, [2] empty_flag
   logic        rsp_tlast;

   request_t     request_queue[$];
   answer_word_t due_answers[$];

   data_type shadow_store[DEPTH];
   ptr_type  shadow_front = '0;
   cnt_type  shadow_count = '0;
   cnt_type  shadow_cursor = cnt_type'(1);

   int   plan_count = 0;
   int   planned = 0;
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   logic long_stall_ask = 1'b0;
   logic long_stall_taken = 1'b0;
   int   stall_left = 0;
   int   error_count = 0;
   int   cycle_count = 0;

   deque_with_cursor i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic ptr_type slot(cnt_type k);
      return ptr_type'((int'(shadow_front) + int'(k)) % DEPTH);
   endfunction

   task automatic model_request(input request_t rq);
      answer_word_t w;
      int           k;
      int           pos;
      w.answer = '0;
      w.status = STAT_OK;
      w.empty = 1'b0;
      w.last = 1'b1;
      case (rq.op)
         OP_EMPTY_Q, OP_SIZE_Q: begin
         end
         OP_PUSH_FRONT: begin
            if (int'(shadow_count) >= DEPTH) begin
               w.status = STAT_FULL;
            end else begin
               shadow_front = (shadow_front == '0) ? ptr_type'(DEPTH - 1)
                                                   : shadow_front - 1'b1;
               shadow_store[shadow_front] = rq.value;
               shadow_count = shadow_count + 1'b1;
            end
         end
         OP_PUSH_BACK: begin
            if (int'(shadow_count) >= DEPTH) begin
               w.status = STAT_FULL;
            end else begin
               shadow_store[slot(shadow_count)] = rq.value;
               shadow_count = shadow_count + 1'b1;
            end
         end
         OP_POP_FRONT: begin
            if (shadow_count != '0) begin
               shadow_front = ptr_type'((int'(shadow_front) + 1) % DEPTH);
               shadow_count = shadow_count - 1'b1;
            end
         end
         OP_POP_BACK: begin
            if (shadow_count != '0) begin
               shadow_count = shadow_count - 1'b1;
            end
         end
         OP_LIST: begin
            for (k = 0; k < int'(shadow_count); k++) begin
               w.answer = shadow_store[slot(cnt_type'(k))];
               w.status = STAT_OK;
               w.empty = 1'b0;
               w.last = (k + 1 == int'(shadow_count));
               due_answers.push_back(w);
            end
            return;
         end
         OP_WALK_START: begin
            shadow_cursor = cnt_type'(1);
         end
         OP_WALK_MOVE: begin
            if (rq.dir == DIR_LEFT) begin
               if (int'(shadow_cursor) > 1) begin
                  shadow_cursor = shadow_cursor - 1'b1;
               end
            end else if (rq.dir == DIR_RIGHT) begin
               if (int'(shadow_cursor) + 1 <= int'(shadow_count)) begin
                  shadow_cursor = shadow_cursor + 1'b1;
               end
            end
         end
         OP_WALK_END: begin
            if (shadow_count == '0) begin
               w.status = STAT_EMPTY;
               w.empty = 1'b1;
            end else begin
               pos = int'(shadow_cursor);
               if (pos > int'(shadow_count)) begin
                  pos = int'(shadow_count);
               end
               if (pos < 1) begin
                  pos = 1;
               end
               w.answer = shadow_store[slot(cnt_type'(pos - 1))];
            end
            due_answers.push_back(w);
            return;
         end
         default: begin
            return;
         end
      endcase
      w.answer = data_type'(shadow_count);
      w.empty = (shadow_count == '0);
      due_answers.push_back(w);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            model_request(request_queue[0]);
            request_queue.pop_front();
         end
         if (!(req_tvalid && !req_tready)) begin
            if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata <= {6'd0, request_queue[0].dir, request_queue[0].value};
               req_tuser <= request_queue[0].op;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (long_stall_ask && !long_stall_taken) begin
         long_stall_taken <= 1'b1;
         stall_left <= LONG_STALL;
         rsp_tready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      answer_word_t got;
      answer_word_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.answer = rsp_tdata;
         got.status = status_type'(rsp_tuser[1:0]);
         got.empty = rsp_tuser[2];
         got.last = rsp_tlast;
         if (due_answers.size() == 0) begin
            error_count++;
            if (error_count < 50) begin
               $display("%0t: unexpected word answer=%h status=%0d empty=%0b last=%0b",
                        $time, got.answer, got.status, got.empty, got.last);
            end
         end else begin
            want = due_answers.pop_front();
            if (got !== want) begin
               error_count++;
               if (error_count < 50) begin
                  $display("%0t: expected answer=%h status=%0d empty=%0b last=%0b",
                           $time, want.answer, want.status, want.empty, want.last);
                  $display("%0t: got      answer=%h status=%0d empty=%0b last=%0b",
                           $time, got.answer, got.status, got.empty, got.last);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT) begin
         $display("%0t: timeout with %0d words still expected", $time, due_answers.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic plan(input logic [3:0] op, input data_type value, input logic [1:0] dir);
      request_t rq;
      rq.op = op;
      rq.value = value;
      rq.dir = dir;
      request_queue.push_back(rq);
      if (op <= OP_WALK_END) begin
         planned++;
      end
      if ((op == OP_PUSH_FRONT || op == OP_PUSH_BACK) && plan_count < DEPTH) begin
         plan_count++;
      end else if ((op == OP_POP_FRONT || op == OP_POP_BACK) && plan_count > 0) begin
         plan_count--;
      end
   endtask

   function automatic data_type pick_value();
      case ($urandom_range(9))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   task automatic plan_random_sequence();
      int n;
      int k;
      int pick;
      pick = $urandom_range(99);
      if (pick < 25) begin
         n = $urandom_range(1, DEPTH + 2);
         for (k = 0; k < n; k++) begin
            plan($urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_value(),
                 2'($urandom));
         end
      end else if (pick < 38) begin
         n = $urandom_range(1, DEPTH / 2);
         for (k = 0; k < n; k++) begin
            plan($urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK, $urandom, 2'($urandom));
         end
      end else if (pick < 65) begin
         plan(OP_WALK_START, $urandom, 2'($urandom));
         n = $urandom_range(1, 8);
         for (k = 0; k < n; k++) begin
            if ($urandom_range(99) < 12) begin
               plan($urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK, $urandom,
                    2'($urandom));
            end else if ($urandom_range(9) < 6) begin
               plan(OP_WALK_MOVE, $urandom, DIR_RIGHT);
            end else begin
               plan(OP_WALK_MOVE, $urandom, 2'($urandom_range(3)));
            end
         end
         plan(OP_WALK_END, $urandom, 2'($urandom));
      end else if (pick < 75) begin
         plan(OP_LIST, $urandom, 2'($urandom));
      end else if (pick < 94) begin
         plan(4'($urandom_range(9)), pick_value(), 2'($urandom));
      end else begin
         plan(4'($urandom_range(10, 15)), $urandom, 2'($urandom));
      end
   endtask

   task automatic settle();
      while (request_queue.size() != 0 || req_tvalid || due_answers.size() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   initial begin
      int c;
      int mark;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      plan(OP_WALK_END, '0, DIR_LEFT);
      plan(OP_POP_FRONT, '0, DIR_LEFT);
      plan(OP_POP_BACK, '0, DIR_LEFT);
      plan(OP_LIST, '0, DIR_LEFT);
      plan(OP_EMPTY_Q, 32'hffff_ffff, 2'd3);
      plan(OP_SIZE_Q, '0, DIR_LEFT);
      plan(OP_WALK_MOVE, '0, DIR_LEFT);
      plan(OP_WALK_MOVE, '0, 2'd3);
      plan(OP_PUSH_FRONT, 32'h7fff_ffff, DIR_LEFT);
      plan(OP_PUSH_BACK, 32'h8000_0000, DIR_LEFT);
      plan(OP_PUSH_FRONT, 32'h0000_0000, DIR_LEFT);
      plan(OP_PUSH_BACK, 32'hffff_ffff, DIR_LEFT);
      plan(OP_WALK_START, '0, DIR_LEFT);
      plan(OP_WALK_MOVE, '0, DIR_RIGHT);
      plan(OP_WALK_MOVE, '0, DIR_RIGHT);
      plan(OP_WALK_MOVE, '0, DIR_STAY);
      plan(OP_WALK_MOVE, '0, DIR_RIGHT);
      plan(OP_WALK_MOVE, '0, DIR_RIGHT);
      plan(OP_WALK_END, '0, DIR_LEFT);
      plan(OP_WALK_MOVE, '0, DIR_LEFT);
      plan(OP_WALK_END, '0, DIR_LEFT);
      plan(4'd10, 32'h1234_5678, DIR_RIGHT);
      plan(OP_LIST, '0, DIR_LEFT);
      plan(OP_POP_FRONT, '0, DIR_LEFT);
      plan(OP_POP_BACK, '0, DIR_LEFT);
      plan(4'd15, 32'hffff_ffff, 2'd3);
      plan(OP_WALK_END, '0, DIR_LEFT);
      settle();

      for (c = 0; c < CHUNKS; c++) begin
         send_idle_pct = (c % 4 == 1) ? 53 : (c % 4 == 3) ? 15 : 0;
         recv_idle_pct = (c % 4 == 2) ? 53 : (c % 4 == 3) ? 15 : 0;
         mark = planned;
         while (planned - mark < CHUNK_ITEMS) begin
            plan_random_sequence();
         end
         if (c == 1) begin
            long_stall_ask = 1'b1;
         end
         settle();
      end

      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
